// ----- rtl/multi_slot_heartbeat_watchdog_defines.svh -----
// Assertion macros for the multi-slot heartbeat watchdog.
// Used by the top level only; expects clk and rst in scope.
`ifndef MULTI_SLOT_HEARTBEAT_WATCHDOG_DEFINES_SVH
`define MULTI_SLOT_HEARTBEAT_WATCHDOG_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/msw_pkg.sv -----
// Shared types and codes for the multi-slot heartbeat watchdog.
// No dependencies; imported by the top level, the front end and the back end.
`timescale 1ns / 1ps

package msw_pkg;

  localparam int SLOT_W  = 5;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 6;

  // input mode codes
  localparam logic [1:0] MODE_TOUCH = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;

  // internal operation codes after classification
  localparam logic [1:0] OP_TOUCH = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  expired_slot;
    logic               expired;
    logic               last;
    logic [COUNT_W-1:0] tracked_count;
  } res_t;

  typedef struct packed {
    logic               scanning;
    logic [COUNT_W-1:0] count;
  } back_stat_t;

endpackage

// ----- rtl/multi_slot_heartbeat_watchdog.sv -----
// Multi-slot heartbeat watchdog, top level.
// Input requests arrive on a queue-style port (push/full) with mode, slot and now_ms.
// Results leave on a queue-style port (empty/pop): expired_slot, expired, last,
// tracked_count. Touch and stop give one result; a check gives one result per
// timed-out slot, in ascending slot order, or a single plain result if none expired.
// The last flag marks the final result of each request.
// Configuration: APB write/read of timeout_ticks (0x0) and missed_limit (0x4).
// A touch/stop/no-op result passes through the command queue and then the result
// queue before it shows on the result ports. A check sweeps the slot table one slot
// per cycle through the beat-time memory read port, holding on a hit while an earlier
// result waits on a full result queue; the back end takes no new command until the
// final result of the check is pushed. Touch and stop sustain one request per cycle
// while the result queue has room.
// A two-entry command queue separates the front end from the back end, so new
// requests are taken while a check is still scanning or results wait.
// When the receiver stops popping, the result queue fills, the back end holds,
// then the command queue fills and full rises; nothing is dropped.
// Reset (rst, synchronous) untracks every slot, zeroes the count, empties both
// queues and restores timeout_ticks to 1000 and missed_limit to 3.
`timescale 1ns / 1ps
`include "multi_slot_heartbeat_watchdog_defines.svh"

module multi_slot_heartbeat_watchdog #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [4:0]  slot,
  input  logic [31:0] now_ms,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  expired_slot,
  output logic        expired,
  output logic        last,
  output logic [5:0]  tracked_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import msw_pkg::*;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MISSED  = 1'b1;

  logic [31:0] timeout_ticks;
  logic [15:0] missed_limit;
  logic        cfg_wr;
  logic        reg_sel;

  logic        cmd_push;
  logic        cmd_full;
  logic        cmd_empty;
  logic        cmd_pop;
  cmd_t        cmd_in;
  cmd_t        cmd_out;

  logic        res_push;
  logic        res_full;
  res_t        res_in;
  res_t        res_out;
  back_stat_t  back_stat;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 32'd1000;
      missed_limit  <= 16'd3;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_TIMEOUT: timeout_ticks <= pwdata;
        REG_MISSED:  missed_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TIMEOUT: prdata = timeout_ticks;
      REG_MISSED:  prdata = {16'b0, missed_limit};
      default:     prdata = '0;
    endcase
  end

  msw_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .push   (push),
    .full   (full),
    .mode   (mode),
    .slot   (slot),
    .now_ms (now_ms),
    .q_full (cmd_full),
    .q_push (cmd_push),
    .cmd    (cmd_in)
  );

  msw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  msw_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .missed_limit  (missed_limit),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd_out),
    .cmd_pop       (cmd_pop),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res_in),
    .stat          (back_stat)
  );

  msw_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign expired_slot  = res_out.expired_slot;
  assign expired       = res_out.expired;
  assign last          = res_out.last;
  assign tracked_count = res_out.tracked_count;

  `MSW_ASSERT_IMPL(a_res_no_overflow, res_push, !res_full, "result pushed into full queue")
  `MSW_ASSERT_IMPL(a_scan_holds_cmd, back_stat.scanning, !cmd_pop, "command popped mid-check")
  `MSW_ASSERT_NEXT(a_count_bound, 1'b1, 32'(back_stat.count) <= SLOTS, "tracked count over SLOTS")

endmodule

// ----- rtl/msw_fifo.sv -----
// Small synchronous queue with a combinational head output.
// Depends on nothing; used for the command and result queues.
`timescale 1ns / 1ps

module msw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ----- rtl/msw_front.sv -----
// Front end: takes input requests and classifies them into commands.
// Depends on msw_pkg; feeds the command queue.
`timescale 1ns / 1ps

module msw_front #(
  parameter int SLOTS = 32
) (
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                mode,
  input  logic [msw_pkg::SLOT_W-1:0] slot,
  input  logic [msw_pkg::TIME_W-1:0] now_ms,
  input  logic                      q_full,
  output logic                      q_push,
  output msw_pkg::cmd_t             cmd
);

  import msw_pkg::*;

  logic in_range;

  // touch or stop on a slot past the table becomes a no-op but is still answered
  assign in_range = (32'(slot) < SLOTS);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    cmd.slot = slot;
    cmd.now  = now_ms;
    unique case (mode)
      MODE_TOUCH: cmd.op = in_range ? OP_TOUCH : OP_NOP;
      MODE_STOP:  cmd.op = in_range ? OP_STOP : OP_NOP;
      MODE_CHECK: cmd.op = OP_CHECK;
      default:    cmd.op = OP_NOP;
    endcase
  end

endmodule

// ----- rtl/msw_back.sv -----
// Back end: slot table, beat-time memory and the timeout scan.
// Depends on msw_pkg; pops the command queue, pushes the result queue.
`timescale 1ns / 1ps

module msw_back #(
  parameter int SLOTS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [31:0]                 timeout_ticks,
  input  logic [15:0]                 missed_limit,
  input  logic                        cmd_empty,
  input  msw_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output msw_pkg::res_t               res,
  output msw_pkg::back_stat_t         stat
);

  import msw_pkg::*;

  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SIW-1:0] LAST_IDX = SIW'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state, state_next;
  logic [SIW-1:0]     idx, idx_next;
  logic [COUNT_W-1:0] cnt, cnt_next;
  logic [SLOTS-1:0]   valid, valid_next;
  logic [TIME_W-1:0]  now_reg, now_reg_next;
  logic               pend_valid, pend_valid_next;
  logic [SLOT_W-1:0]  pend_slot, pend_slot_next;
  logic [COUNT_W-1:0] pend_count, pend_count_next;

  logic [TIME_W-1:0]  mem [SLOTS];
  logic [TIME_W-1:0]  rdata;
  logic [SIW-1:0]     rd_addr;
  logic               mem_we;
  logic [SIW-1:0]     cmd_idx;

  logic [31:0]        period;
  logic [47:0]        prod;
  logic [47:0]        thr;
  logic [TIME_W-1:0]  elapsed;
  logic               hit;
  logic               stall;

  // threshold: elapsed >= period and elapsed/period >= limit
  // is the same as elapsed >= max(period, limit*period)
  assign period = (timeout_ticks == '0) ? 32'd1 : timeout_ticks;
  assign prod   = missed_limit * period;

  always_ff @(posedge clk) begin
    thr <= (missed_limit == '0) ? {16'b0, period} : prod;
  end

  assign cmd_idx = SIW'(cmd.slot);
  assign elapsed = now_reg - rdata;
  assign hit     = valid[idx] && ({16'b0, elapsed} >= thr);
  assign stall   = hit && pend_valid && res_full;

  assign stat.scanning = (state != ST_IDLE);
  assign stat.count    = cnt;

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    cnt_next        = cnt;
    valid_next      = valid;
    now_reg_next    = now_reg;
    pend_valid_next = pend_valid;
    pend_slot_next  = pend_slot;
    pend_count_next = pend_count;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    res             = '0;
    mem_we          = 1'b0;
    rd_addr         = '0;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.op == OP_CHECK) begin
            // read of slot 0 goes out now, scan starts next cycle
            cmd_pop         = 1'b1;
            now_reg_next    = cmd.now;
            idx_next        = '0;
            pend_valid_next = 1'b0;
            state_next      = ST_SCAN;
          end else if (!res_full) begin
            cmd_pop  = 1'b1;
            res_push = 1'b1;
            case (cmd.op)
              OP_TOUCH: begin
                mem_we = 1'b1;
                if (!valid[cmd_idx]) begin
                  valid_next[cmd_idx] = 1'b1;
                  cnt_next            = cnt + 1'b1;
                end
              end
              OP_STOP: begin
                if (valid[cmd_idx]) begin
                  valid_next[cmd_idx] = 1'b0;
                  cnt_next            = cnt - 1'b1;
                end
              end
              default: ;
            endcase
            res.last          = 1'b1;
            res.tracked_count = cnt_next;
          end
        end
      end
      ST_SCAN: begin
        if (stall) begin
          rd_addr = idx;
        end else begin
          rd_addr = (idx == LAST_IDX) ? '0 : idx + 1'b1;
          if (hit) begin
            // hold each hit back one step so the final one can carry last
            valid_next[idx] = 1'b0;
            cnt_next        = cnt - 1'b1;
            if (pend_valid) begin
              res_push          = 1'b1;
              res.expired_slot  = pend_slot;
              res.expired       = 1'b1;
              res.tracked_count = pend_count;
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = SLOT_W'(idx);
            pend_count_next = cnt - 1'b1;
          end
          if (idx == LAST_IDX) begin
            state_next = ST_FIN;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (!res_full) begin
          res_push = 1'b1;
          res.last = 1'b1;
          if (pend_valid) begin
            res.expired_slot  = pend_slot;
            res.expired       = 1'b1;
            res.tracked_count = pend_count;
          end else begin
            res.tracked_count = cnt;
          end
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      cnt        <= '0;
      valid      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      cnt        <= cnt_next;
      valid      <= valid_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    now_reg    <= now_reg_next;
    pend_slot  <= pend_slot_next;
    pend_count <= pend_count_next;
  end

  // beat-time memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd_idx] <= cmd.now;
    end
    rdata <= mem[rd_addr];
  end

endmodule
